// ----- src/fk_pkg.sv -----
// Shared types, constants and helper functions for the seven-joint forward
// kinematics pipeline. Used by every module of the block; depends on nothing.
`default_nettype none

package fk_pkg;

    // Geometry of the arm and of the pipeline
    localparam int NUM_JOINTS       = 7;
    localparam int CORDIC_ITER_DEF  = 16;
    localparam int NUM_ENTRIES      = 12;

    // Field widths
    localparam int ANGLE_W   = 18;
    localparam int OUT_W     = 20;
    localparam int CORD_W    = 34;   // CORDIC x, y, z in Q.30 with headroom
    localparam int TRIG_W    = 27;   // sin / cos / a*trig in Q.24
    localparam int LINK_W    = 24;   // link constants in Q.24
    localparam int ENTRY_W   = 32;   // pose entry in Q.24, clamped to +-2^30
    localparam int PROD_W    = 59;   // entry times trig value
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 240;

    // Fixed-point constants
    localparam logic signed [CORD_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [CORD_W-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [CORD_W-1:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [ENTRY_W-1:0] ONE_Q24    = 32'sd16777216;
    localparam logic signed [63:0] ENTRY_LIMIT       = 64'sd1073741824;

    // One CORDIC lane
    typedef struct packed {
        logic signed [CORD_W-1:0] x;
        logic signed [CORD_W-1:0] y;
        logic signed [CORD_W-1:0] z;
        logic                     flip;
    } t_cordic;
    typedef t_cordic [NUM_JOINTS-1:0] t_cordic_vec;

    // Per-joint trig terms handed along the joint chain
    typedef struct packed {
        logic signed [TRIG_W-1:0] st;
        logic signed [TRIG_W-1:0] ct;
        logic signed [TRIG_W-1:0] ma_c;   // round(a*ct)
        logic signed [TRIG_W-1:0] ma_s;   // round(a*st)
    } t_trig;
    typedef t_trig [NUM_JOINTS-1:0] t_trig_vec;

    // Pose: 3 rows by 4 columns, entry index is row*4 + column
    typedef logic signed [ENTRY_W-1:0] t_entry;
    typedef t_entry [NUM_ENTRIES-1:0] t_pose;

    // atan(2^-i) in Q.30, truncated
    function automatic logic [31:0] fk_atan(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    // Link length a in Q.24
    function automatic logic signed [LINK_W-1:0] fk_link_a(input int j);
        logic signed [LINK_W-1:0] v;
        case (j)
            3:       v = 24'sd1384120;
            4:       v = -24'sd1384120;
            6:       v = 24'sd1476395;
            default: v = 24'sd0;
        endcase
        return v;
    endfunction

    // Link offset d in Q.24
    function automatic logic signed [LINK_W-1:0] fk_link_d(input int j);
        logic signed [LINK_W-1:0] v;
        case (j)
            0:       v = 24'sd5586813;
            2:       v = 24'sd5301600;
            4:       v = 24'sd6442451;
            6:       v = 24'sd1795162;
            default: v = 24'sd0;
        endcase
        return v;
    endfunction

    // sin(alpha): -1, 0 or +1
    function automatic int fk_link_sa(input int j);
        int v;
        case (j)
            0, 4:    v = -1;
            6:       v = 0;
            default: v = 1;
        endcase
        return v;
    endfunction

    // cos(alpha): only the last link has alpha = 0
    function automatic int fk_link_ca(input int j);
        return (j == NUM_JOINTS - 1) ? 1 : 0;
    endfunction

    // Round Q.48 to Q.24 (toward +inf on ties) and clamp to +-2^30
    function automatic logic signed [ENTRY_W-1:0] fk_round_clamp(
        input logic signed [63:0] v);
        logic signed [63:0] r;
        r = (v + 64'sd8388608) >>> 24;
        if (r > ENTRY_LIMIT) begin
            r = ENTRY_LIMIT;
        end else if (r < -ENTRY_LIMIT) begin
            r = -ENTRY_LIMIT;
        end
        return r[ENTRY_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- src/dh_forward_kinematics_7dof.sv -----
// Top level of the seven-joint forward kinematics pipeline.
// Depends on fk_pkg, fk_cordic_cell, fk_trig_prep and fk_joint_cell.
//
// Usage:
//   Slave channel (i_s_*): one item holds seven joint angles, signed Q2.15.
//   Master channel (o_m_*): one item holds the top three rows of the pose,
//   twelve signed Q3.16 values, row by row, position in the last column.
//   The block is a single pipeline: an input register that folds the angle
//   into +-pi/2, CORDIC_ITERATIONS CORDIC cells working on all joints at
//   once, three trig preparation stages, seven link cells of two stages
//   each, and an output register.
//   Throughput: one item per cycle unless the output stalls; every stage
//   is a plain register that takes a new item in each cycle it is enabled,
//   so items can follow back to back.
//   Stall: while the output item waits and the receiver holds tready low,
//   the whole pipeline holds and o_s_tready is low; all items in flight
//   are kept. Otherwise an item is taken even while a result is shown.
//   Reset: clears all valid flags; no item is in flight after reset.
`default_nettype none

module dh_forward_kinematics_7dof #(
    parameter int CORDIC_ITERATIONS = fk_pkg::CORDIC_ITER_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // joint1_angle .. joint7_angle, 18 bits each, then 2 zero bits
    input  wire logic [fk_pkg::IN_DATA_W-1:0]  i_s_tdata,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // rot_r0c0 rot_r0c1 rot_r0c2 pos_x rot_r1c0 rot_r1c1 rot_r1c2 pos_y
    // rot_r2c0 rot_r2c1 rot_r2c2 pos_z, 20 bits each
    output logic [fk_pkg::OUT_DATA_W-1:0]      o_m_tdata
);

    localparam int NJ = fk_pkg::NUM_JOINTS;

    logic w_en;

    logic                r_front_valid;
    fk_pkg::t_cordic_vec r_front;
    fk_pkg::t_cordic_vec n_front;

    fk_pkg::t_cordic_vec w_cord       [CORDIC_ITERATIONS+1];
    logic                w_cord_valid [CORDIC_ITERATIONS+1];

    logic                w_trig_valid;
    fk_pkg::t_trig_vec   w_trig;

    fk_pkg::t_pose       w_pose       [NJ+1];
    fk_pkg::t_trig_vec   w_jtrig      [NJ+1];
    logic                w_pose_valid [NJ+1];

    fk_pkg::t_pose       w_ident;

    logic                            r_out_valid;
    logic [fk_pkg::OUT_DATA_W-1:0]   r_out_data;
    logic [fk_pkg::OUT_DATA_W-1:0]   n_out_data;

    // Whole pipeline moves unless a result is stuck at the output
    assign w_en       = !r_out_valid || i_m_tready;
    assign o_s_tready = w_en;

    // Angle to Q.30, folded into +-pi/2
    always_comb begin
        logic signed [fk_pkg::CORD_W-1:0] z;
        for (int l = 0; l < NJ; l++) begin
            z = {i_s_tdata[fk_pkg::ANGLE_W*l + fk_pkg::ANGLE_W - 1],
                 i_s_tdata[fk_pkg::ANGLE_W*l +: fk_pkg::ANGLE_W], 15'b0};
            n_front[l].x    = fk_pkg::GAIN_Q30;
            n_front[l].y    = '0;
            n_front[l].flip = 1'b0;
            if (z > fk_pkg::HALF_PI_Q30) begin
                z = z - fk_pkg::PI_Q30;
                n_front[l].flip = 1'b1;
            end else if (z < -fk_pkg::HALF_PI_Q30) begin
                z = z + fk_pkg::PI_Q30;
                n_front[l].flip = 1'b1;
            end
            n_front[l].z = z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_valid <= 1'b0;
        end else if (w_en) begin
            r_front_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_front <= n_front;
        end
    end

    assign w_cord[0]       = r_front;
    assign w_cord_valid[0] = r_front_valid;

    // CORDIC chain
    genvar i;
    generate
        for (i = 0; i < CORDIC_ITERATIONS; i++) begin : g_cordic
            fk_cordic_cell #(
                .STEP (i)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_valid (w_cord_valid[i]),
                .i_lanes (w_cord[i]),
                .o_valid (w_cord_valid[i+1]),
                .o_lanes (w_cord[i+1])
            );
        end
    endgenerate

    fk_trig_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cord_valid[CORDIC_ITERATIONS]),
        .i_lanes (w_cord[CORDIC_ITERATIONS]),
        .o_valid (w_trig_valid),
        .o_trig  (w_trig)
    );

    // Identity pose feeding the first link
    always_comb begin
        for (int k = 0; k < fk_pkg::NUM_ENTRIES; k++) begin
            w_ident[k] = ((k % 4) == (k / 4)) ? fk_pkg::ONE_Q24 : '0;
        end
    end

    assign w_pose[0]       = w_ident;
    assign w_jtrig[0]      = w_trig;
    assign w_pose_valid[0] = w_trig_valid;

    // Link chain
    genvar j;
    generate
        for (j = 0; j < NJ; j++) begin : g_joint
            fk_joint_cell #(
                .JOINT (j)
            ) u_joint (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_valid (w_pose_valid[j]),
                .i_pose  (w_pose[j]),
                .i_trig  (w_jtrig[j]),
                .o_valid (w_pose_valid[j+1]),
                .o_pose  (w_pose[j+1]),
                .o_trig  (w_jtrig[j+1])
            );
        end
    endgenerate

    // Q.24 -> Q3.16 with rounding and saturation
    function automatic logic [fk_pkg::OUT_W-1:0] fk_out_sat(
        input logic signed [fk_pkg::ENTRY_W-1:0] e);
        logic signed [fk_pkg::ENTRY_W:0] q;
        q = (33'(e) + 33'sd128) >>> 8;
        if (q > 33'sd524287) begin
            q = 33'sd524287;
        end else if (q < -33'sd524288) begin
            q = -33'sd524288;
        end
        return q[fk_pkg::OUT_W-1:0];
    endfunction

    always_comb begin
        for (int k = 0; k < fk_pkg::NUM_ENTRIES; k++) begin
            n_out_data[fk_pkg::OUT_W*k +: fk_pkg::OUT_W] = fk_out_sat(w_pose[NJ][k]);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_pose_valid[NJ];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // An accepted item lands in the input stage
    a_front_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_front_valid)
        else $error("accepted item not captured in input stage");

    // A stalled pipeline keeps its input stage
    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en) |=> $stable(r_front_valid))
        else $error("input stage changed during stall");

    // Final x position lies inside the clamp window
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pose_valid[NJ] |->
            ($signed(w_pose[NJ][3]) <= 32'sd1073741824 &&
             $signed(w_pose[NJ][3]) >= -32'sd1073741824))
        else $error("pose entry outside clamp window");

endmodule

`default_nettype wire

// ----- src/fk_cordic_cell.sv -----
// One CORDIC rotation step for all seven joint lanes, registered.
// Depends on fk_pkg.
`default_nettype none

module fk_cordic_cell #(
    parameter int STEP = 0
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_valid,
    input  wire fk_pkg::t_cordic_vec i_lanes,
    output logic                     o_valid,
    output fk_pkg::t_cordic_vec      o_lanes
);

    localparam logic signed [fk_pkg::CORD_W-1:0] ATAN =
        fk_pkg::CORD_W'(fk_pkg::fk_atan(STEP));

    logic                r_valid;
    fk_pkg::t_cordic_vec r_lanes;
    fk_pkg::t_cordic_vec n_lanes;

    // Rotate toward z = 0, direction from the sign of z
    always_comb begin
        for (int l = 0; l < fk_pkg::NUM_JOINTS; l++) begin
            n_lanes[l].flip = i_lanes[l].flip;
            if (!i_lanes[l].z[fk_pkg::CORD_W-1]) begin
                n_lanes[l].x = i_lanes[l].x - (i_lanes[l].y >>> STEP);
                n_lanes[l].y = i_lanes[l].y + (i_lanes[l].x >>> STEP);
                n_lanes[l].z = i_lanes[l].z - ATAN;
            end else begin
                n_lanes[l].x = i_lanes[l].x + (i_lanes[l].y >>> STEP);
                n_lanes[l].y = i_lanes[l].y - (i_lanes[l].x >>> STEP);
                n_lanes[l].z = i_lanes[l].z + ATAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lanes <= n_lanes;
        end
    end

    assign o_valid = r_valid;
    assign o_lanes = r_lanes;

endmodule

`default_nettype wire

// ----- src/fk_trig_prep.sv -----
// Turns CORDIC results into Q.24 sin/cos and the rounded a*cos, a*sin terms
// for every joint, in three registered stages. Depends on fk_pkg.
`default_nettype none

module fk_trig_prep (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_valid,
    input  wire fk_pkg::t_cordic_vec i_lanes,
    output logic                     o_valid,
    output fk_pkg::t_trig_vec        o_trig
);

    localparam int PA_W = fk_pkg::LINK_W + fk_pkg::TRIG_W - 1;

    logic [2:0] r_valid;

    logic signed [fk_pkg::TRIG_W-1:0] r1_st [fk_pkg::NUM_JOINTS];
    logic signed [fk_pkg::TRIG_W-1:0] r1_ct [fk_pkg::NUM_JOINTS];
    logic signed [fk_pkg::TRIG_W-1:0] r2_st [fk_pkg::NUM_JOINTS];
    logic signed [fk_pkg::TRIG_W-1:0] r2_ct [fk_pkg::NUM_JOINTS];
    logic signed [PA_W-1:0]           r2_pc [fk_pkg::NUM_JOINTS];
    logic signed [PA_W-1:0]           r2_ps [fk_pkg::NUM_JOINTS];
    fk_pkg::t_trig_vec                r3_trig;

    genvar l;
    generate
        for (l = 0; l < fk_pkg::NUM_JOINTS; l++) begin : g_lane
            localparam logic signed [fk_pkg::LINK_W-1:0] A = fk_pkg::fk_link_a(l);

            logic signed [fk_pkg::CORD_W-1:0] w_xr;
            logic signed [fk_pkg::CORD_W-1:0] w_yr;
            logic signed [PA_W-1:0]           w_rc;
            logic signed [PA_W-1:0]           w_rs;

            // Q.30 -> Q.24 with rounding, negated when the angle was folded
            always_comb begin
                w_xr = (i_lanes[l].x + 34'sd32) >>> 6;
                w_yr = (i_lanes[l].y + 34'sd32) >>> 6;
                if (i_lanes[l].flip) begin
                    w_xr = -w_xr;
                    w_yr = -w_yr;
                end
            end

            // Round a*trig from Q.48 to Q.24
            assign w_rc = (r2_pc[l] + PA_W'(25'sd8388608)) >>> 24;
            assign w_rs = (r2_ps[l] + PA_W'(25'sd8388608)) >>> 24;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r1_ct[l]         <= w_xr[fk_pkg::TRIG_W-1:0];
                    r1_st[l]         <= w_yr[fk_pkg::TRIG_W-1:0];
                    r2_ct[l]         <= r1_ct[l];
                    r2_st[l]         <= r1_st[l];
                    r2_pc[l]         <= A * r1_ct[l];
                    r2_ps[l]         <= A * r1_st[l];
                    r3_trig[l].ct    <= r2_ct[l];
                    r3_trig[l].st    <= r2_st[l];
                    r3_trig[l].ma_c  <= w_rc[fk_pkg::TRIG_W-1:0];
                    r3_trig[l].ma_s  <= w_rs[fk_pkg::TRIG_W-1:0];
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 3'b000;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    assign o_valid = r_valid[2];
    assign o_trig  = r3_trig;

endmodule

`default_nettype wire

// ----- src/fk_joint_cell.sv -----
// One Denavit-Hartenberg link: multiplies the running pose by the link
// transform in two registered stages and passes the trig terms on.
// Depends on fk_pkg.
`default_nettype none

module fk_joint_cell #(
    parameter int JOINT = 0
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire fk_pkg::t_pose     i_pose,
    input  wire fk_pkg::t_trig_vec i_trig,
    output logic                   o_valid,
    output fk_pkg::t_pose          o_pose,
    output fk_pkg::t_trig_vec      o_trig
);

    localparam logic signed [fk_pkg::LINK_W-1:0] D = fk_pkg::fk_link_d(JOINT);
    localparam int SA = fk_pkg::fk_link_sa(JOINT);
    localparam int CA = fk_pkg::fk_link_ca(JOINT);

    fk_pkg::t_trig w_tr;

    // Stage 1: products
    logic                               r1_valid;
    fk_pkg::t_trig_vec                  r1_trig;
    logic signed [fk_pkg::PROD_W-1:0]   r1_p_cc [3];  // t0*ct
    logic signed [fk_pkg::PROD_W-1:0]   r1_p_ss [3];  // t1*st
    logic signed [fk_pkg::PROD_W-1:0]   r1_p_sc [3];  // t0*st
    logic signed [fk_pkg::PROD_W-1:0]   r1_p_cs [3];  // t1*ct
    logic signed [fk_pkg::PROD_W-1:0]   r1_p_xa [3];  // t0*round(a*ct)
    logic signed [fk_pkg::PROD_W-1:0]   r1_p_ya [3];  // t1*round(a*st)
    logic signed [fk_pkg::PROD_W-1:0]   r1_p_zd [3];  // t2*d
    logic signed [fk_pkg::ENTRY_W-1:0]  r1_t2 [3];
    logic signed [fk_pkg::ENTRY_W-1:0]  r1_t3 [3];

    // Stage 2: new pose
    logic                r2_valid;
    fk_pkg::t_trig_vec   r2_trig;
    fk_pkg::t_pose       r2_pose;
    fk_pkg::t_pose       n_pose;

    assign w_tr = i_trig[JOINT];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_trig <= i_trig;
            for (int r = 0; r < 3; r++) begin
                r1_p_cc[r] <= $signed(i_pose[4*r])   * w_tr.ct;
                r1_p_ss[r] <= $signed(i_pose[4*r+1]) * w_tr.st;
                r1_p_sc[r] <= $signed(i_pose[4*r])   * w_tr.st;
                r1_p_cs[r] <= $signed(i_pose[4*r+1]) * w_tr.ct;
                r1_p_xa[r] <= $signed(i_pose[4*r])   * w_tr.ma_c;
                r1_p_ya[r] <= $signed(i_pose[4*r+1]) * w_tr.ma_s;
                r1_p_zd[r] <= $signed(i_pose[4*r+2]) * D;
                r1_t2[r]   <= $signed(i_pose[4*r+2]);
                r1_t3[r]   <= $signed(i_pose[4*r+3]);
            end
        end
    end

    // Sum, round and clamp each new entry but the one taken from the old third column
    always_comb begin
        logic signed [63:0] q;
        logic signed [63:0] s;
        for (int r = 0; r < 3; r++) begin
            q = 64'(r1_p_cs[r]) - 64'(r1_p_sc[r]);
            s = (64'(r1_t3[r]) <<< 24) + 64'(r1_p_xa[r]) + 64'(r1_p_ya[r])
                + 64'(r1_p_zd[r]);
            n_pose[4*r] = fk_pkg::fk_round_clamp(64'(r1_p_cc[r]) + 64'(r1_p_ss[r]));
            if (CA != 0) begin
                // alpha = 0: middle column is the rotated one, third stays
                n_pose[4*r+1] = fk_pkg::fk_round_clamp(q);
                n_pose[4*r+2] = r1_t2[r];
            end else if (SA > 0) begin
                n_pose[4*r+1] = r1_t2[r];
                n_pose[4*r+2] = fk_pkg::fk_round_clamp(-q);
            end else begin
                n_pose[4*r+1] = -r1_t2[r];
                n_pose[4*r+2] = fk_pkg::fk_round_clamp(q);
            end
            n_pose[4*r+3] = fk_pkg::fk_round_clamp(s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_trig <= r1_trig;
            r2_pose <= n_pose;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
    end

    assign o_valid = r2_valid;
    assign o_pose  = r2_pose;
    assign o_trig  = r2_trig;

endmodule

`default_nettype wire
